// ===== rtl/led_fade_waveform_generator_unit_macros.svh =====
// assertion macros shared by the fade generator checker
// no dependencies; included by the checker file only
`ifndef LED_FADE_WAVEFORM_GENERATOR_UNIT_MACROS_SVH
`define LED_FADE_WAVEFORM_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LFWG_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define LFWG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lfwg_pkg.sv =====
// shared types, codes and the sine table builder for the fade generator
// no dependencies; used by every other file except the macros header
package lfwg_pkg;

    // configuration port layout
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // fixed field widths
    localparam int STEP_W   = 17;
    localparam int PERIOD_W = 16;
    localparam int LEVEL_W  = 8;
    localparam int COLOUR_W = 3;
    localparam int MAG_W    = 16;

    // command queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // sine table constants in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FADE_MODE    = 2'd0,
        REG_PERIOD_STEPS = 2'd1,
        REG_MAX_LEVEL    = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        MODE_NONE     = 3'd0,
        MODE_SINE     = 3'd1,
        MODE_SQUARE   = 3'd2,
        MODE_TRIANGLE = 3'd3,
        MODE_SAWTOOTH = 3'd4,
        MODE_COLOUR   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        OP_SINE,
        OP_SQUARE,
        OP_TRIANGLE,
        OP_SAWTOOTH
    } op_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_DIVIDE,
        B_LOOKUP,
        B_SUM,
        B_HOLD
    } back_state_t;

    // one queued tick: waveform operands plus colour status
    typedef struct packed {
        op_t                 op;
        logic [STEP_W-1:0]   step;
        logic [PERIOD_W-1:0] period;
        logic [LEVEL_W-1:0]  max_level;
        logic [COLOUR_W-1:0] colour;
        logic                advanced;
    } cmd_t;

    // quarter-wave sine entry i of a table with 2^bits steps, unsigned Q1.15
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned i,
                                                    input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (HALF_PI_Q30 * 64'(i)) >> bits;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32768)
        begin
            s = 64'd32768;
        end
        return s[MAG_W-1:0];
    endfunction

endpackage

// ===== rtl/lfwg_if.sv =====
// channel interfaces: tick input, level result and configuration write
// depends on lfwg_pkg for field widths
interface lfwg_tick_if;
    logic valid;
    logic ready;
    logic step_tick;

    modport source (output valid, output step_tick, input ready);
    modport sink (input valid, input step_tick, output ready);
endinterface

interface lfwg_result_if;
    logic                          valid;
    logic                          ready;
    logic [lfwg_pkg::LEVEL_W-1:0]  level;
    logic [lfwg_pkg::COLOUR_W-1:0] colour_index;
    logic                          colour_advanced;

    modport source (output valid, output level, output colour_index,
                    output colour_advanced, input ready);
    modport sink (input valid, input level, input colour_index,
                  input colour_advanced, output ready);
endinterface

interface lfwg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lfwg_pkg::CFG_INDEX_W-1:0] index;
    logic [lfwg_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lfwg_fifo.sv =====
// short command queue between the tick front end and the level back end
// depends on lfwg_pkg for cmd_t and the queue depth
module lfwg_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lfwg_pkg::cmd_t push_cmd,
    input  logic           pop,
    output lfwg_pkg::cmd_t head_cmd,
    output logic           empty,
    output logic           full
);

    localparam int CNT_W = $clog2(lfwg_pkg::QUEUE_DEPTH + 1);

    lfwg_pkg::cmd_t              entries_reg [lfwg_pkg::QUEUE_DEPTH];
    logic [lfwg_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lfwg_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(lfwg_pkg::QUEUE_DEPTH));
    assign head_cmd = entries_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == lfwg_pkg::QPTR_W'(lfwg_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + lfwg_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lfwg_pkg::QPTR_W'(lfwg_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + lfwg_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/lfwg_front.sv =====
// front end: config registers, tick classification, step and colour counters
// depends on lfwg_pkg and the channel interfaces in lfwg_if.sv
module lfwg_front #(
    parameter int COLOUR_COUNT = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    lfwg_tick_if.sink      tick,
    lfwg_cfg_if.sink       cfg,
    input  logic           queue_full,
    output logic           push,
    output lfwg_pkg::cmd_t push_cmd
);

    localparam int CW = (COLOUR_COUNT > 1) ? $clog2(COLOUR_COUNT) : 1;

    lfwg_pkg::mode_t                  mode_reg;
    logic [lfwg_pkg::PERIOD_W-1:0]    period_reg;
    logic [lfwg_pkg::LEVEL_W-1:0]     max_reg;
    logic [lfwg_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [CW-1:0]                    colour_reg, colour_next;
    logic [lfwg_pkg::STEP_W-1:0]      step_inc;
    logic [CW-1:0]                    colour_inc;
    logic [CW-1:0]                    colour_after;
    logic                             wrap;
    logic                             advance;
    logic                             active;
    lfwg_pkg::op_t                    op;

    assign tick.ready = !queue_full;
    assign cfg.ready  = 1'b1;

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= lfwg_pkg::MODE_NONE;
            period_reg <= '0;
            max_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                lfwg_pkg::REG_FADE_MODE:
                    mode_reg <= lfwg_pkg::mode_t'(cfg.data[2:0]);
                lfwg_pkg::REG_PERIOD_STEPS:
                    period_reg <= cfg.data[lfwg_pkg::PERIOD_W-1:0];
                lfwg_pkg::REG_MAX_LEVEL:
                    max_reg <= cfg.data[lfwg_pkg::LEVEL_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // mode decode
    always_comb
    begin
        unique case (mode_reg) inside
            lfwg_pkg::MODE_SINE, lfwg_pkg::MODE_COLOUR:
            begin
                active = 1'b1;
                op     = lfwg_pkg::OP_SINE;
            end
            lfwg_pkg::MODE_SQUARE:
            begin
                active = 1'b1;
                op     = lfwg_pkg::OP_SQUARE;
            end
            lfwg_pkg::MODE_TRIANGLE:
            begin
                active = 1'b1;
                op     = lfwg_pkg::OP_TRIANGLE;
            end
            lfwg_pkg::MODE_SAWTOOTH:
            begin
                active = 1'b1;
                op     = lfwg_pkg::OP_SAWTOOTH;
            end
            default:
            begin
                active = 1'b0;
                op     = lfwg_pkg::OP_SQUARE;
            end
        endcase
    end

    // step wrap and colour advance
    always_comb
    begin
        step_inc     = step_reg + lfwg_pkg::STEP_W'(1);
        wrap         = (step_inc > {1'b0, period_reg});
        advance      = wrap && (mode_reg == lfwg_pkg::MODE_COLOUR);
        colour_inc   = (colour_reg == CW'(COLOUR_COUNT - 1)) ? '0 : colour_reg + CW'(1);
        colour_after = advance ? colour_inc : colour_reg;
        push         = tick.valid && !queue_full && tick.step_tick && active;
        step_next    = step_reg;
        colour_next  = colour_reg;
        if (push)
        begin
            step_next   = wrap ? '0 : step_inc;
            colour_next = colour_after;
        end
        push_cmd.op        = op;
        push_cmd.step      = step_reg;
        push_cmd.period    = period_reg;
        push_cmd.max_level = max_reg;
        push_cmd.colour    = lfwg_pkg::COLOUR_W'(colour_after);
        push_cmd.advanced  = advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            colour_reg <= '0;
        end
        else
        begin
            step_reg   <= step_next;
            colour_reg <= colour_next;
        end
    end

endmodule

// ===== rtl/lfwg_divider.sv =====
// restoring radix-2 divider, one quotient bit per cycle
// depends on lfwg_pkg for the divisor width
module lfwg_divider #(
    parameter int NUM_W = 30
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [NUM_W-1:0]              numer,
    input  logic [lfwg_pkg::PERIOD_W-1:0] denom,
    output logic [NUM_W-1:0]              quotient,
    output logic                          done
);

    localparam int DW    = lfwg_pkg::PERIOD_W;
    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DW:0]      shifted;
    logic [DW:0]      diff;
    logic             fits;

    assign quotient = quo_reg;
    assign done     = done_reg;

    // one trial subtraction per cycle
    always_comb
    begin
        shifted    = {rem_reg, quo_reg[NUM_W-1]};
        diff       = shifted - {1'b0, den_reg};
        fits       = (shifted >= {1'b0, den_reg});
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        if (start)
        begin
            quo_next   = numer;
            rem_next   = '0;
            den_next   = denom;
            count_next = '0;
            busy_next  = 1'b1;
            done_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next   = {quo_reg[NUM_W-2:0], fits};
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

// ===== rtl/lfwg_sine_rom.sv =====
// quarter-wave sine table, 2^TABLE_BITS + 1 constant entries, registered read
// depends on lfwg_pkg::sine_entry, evaluated at elaboration
module lfwg_sine_rom #(
    parameter int TABLE_BITS = 8
) (
    input  logic                         clk,
    input  logic [TABLE_BITS:0]          addr,
    output logic [lfwg_pkg::MAG_W-1:0]   data
);

    localparam int QSTEPS = 1 << TABLE_BITS;

    logic [lfwg_pkg::MAG_W-1:0] rom_word [QSTEPS + 1];
    logic [lfwg_pkg::MAG_W-1:0] data_reg;

    // constant contents
    for (genvar i = 0; i <= QSTEPS; i++)
    begin : g_word
        assign rom_word[i] = lfwg_pkg::sine_entry(i, TABLE_BITS);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_word[addr];
    end

    assign data = data_reg;

endmodule

// ===== rtl/lfwg_back.sv =====
// back end: computes the level of each queued tick and holds the result
// depends on lfwg_pkg, lfwg_if.sv, lfwg_divider and lfwg_sine_rom
module lfwg_back #(
    parameter int SINE_TABLE_BITS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           queue_empty,
    input  lfwg_pkg::cmd_t head_cmd,
    output logic           pop,
    lfwg_result_if.source  result
);

    localparam int QSTEPS = 1 << SINE_TABLE_BITS;
    localparam int ADDR_W = SINE_TABLE_BITS + 1;
    localparam int NUM_W  = (SINE_TABLE_BITS + 18 > 25) ? SINE_TABLE_BITS + 18 : 25;
    localparam int PROD_W = lfwg_pkg::MAG_W + lfwg_pkg::LEVEL_W - 1;
    localparam int SUM_W  = PROD_W;
    localparam int MUL_W  = lfwg_pkg::STEP_W + lfwg_pkg::LEVEL_W;
    localparam int LW     = lfwg_pkg::LEVEL_W;

    lfwg_pkg::back_state_t         state_reg, state_next;
    lfwg_pkg::cmd_t                cmd_reg, cmd_next;
    logic [LW-1:0]                 level_reg, level_next;
    logic [PROD_W-1:0]             prod_reg, prod_next;
    logic                          out_valid_reg, out_valid_next;
    logic [LW-1:0]                 out_level_reg;
    logic [lfwg_pkg::COLOUR_W-1:0] out_colour_reg;
    logic                          out_adv_reg;
    logic                          out_load;

    logic [lfwg_pkg::PERIOD_W-2:0] half;
    logic [lfwg_pkg::STEP_W-1:0]   mul_a;
    logic [MUL_W-1:0]              mul_p;
    logic                          below_half;
    logic                          div_start;
    logic [NUM_W-1:0]              div_num;
    logic [lfwg_pkg::PERIOD_W-1:0] div_den;
    logic [NUM_W-1:0]              div_q;
    logic                          div_done;
    logic [1:0]                    quad;
    logic [SINE_TABLE_BITS-1:0]    offset;
    logic [ADDR_W-1:0]             rom_addr;
    logic [lfwg_pkg::MAG_W-1:0]    rom_data;
    logic [SUM_W-1:0]              base;
    logic [SUM_W-1:0]              sum;

    lfwg_divider #(
        .NUM_W (NUM_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_num),
        .denom    (div_den),
        .quotient (div_q),
        .done     (div_done)
    );

    // table address from the phase held in the quotient
    assign quad     = div_q[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
    assign offset   = div_q[SINE_TABLE_BITS-1:0];
    assign rom_addr = quad[0] ? (ADDR_W'(QSTEPS) - {1'b0, offset}) : {1'b0, offset};

    lfwg_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    // operand setup: one multiplier shared by ramp numerators
    always_comb
    begin
        half       = cmd_reg.period[lfwg_pkg::PERIOD_W-1:1];
        below_half = (cmd_reg.step < lfwg_pkg::STEP_W'(half));
        mul_a      = ((cmd_reg.op == lfwg_pkg::OP_TRIANGLE) && !below_half)
                     ? lfwg_pkg::STEP_W'(cmd_reg.period - cmd_reg.step[lfwg_pkg::PERIOD_W-1:0])
                     : cmd_reg.step;
        mul_p      = mul_a * MUL_W'(cmd_reg.max_level);
        base       = SUM_W'(cmd_reg.max_level) << 14;
        sum        = quad[1] ? (base - prod_reg) : (base + prod_reg);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        level_next = level_reg;
        prod_next  = prod_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        div_num    = NUM_W'(mul_p);
        div_den    = cmd_reg.period;
        out_load   = 1'b0;
        unique case (state_reg)
            lfwg_pkg::B_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head_cmd;
                    state_next = lfwg_pkg::B_LOAD;
                end
            end
            lfwg_pkg::B_LOAD:
            begin
                level_next = '0;
                state_next = lfwg_pkg::B_HOLD;
                case (cmd_reg.op)
                    lfwg_pkg::OP_SQUARE:
                    begin
                        level_next = below_half ? cmd_reg.max_level : '0;
                    end
                    lfwg_pkg::OP_SAWTOOTH:
                    begin
                        if (cmd_reg.period != '0)
                        begin
                            div_start  = 1'b1;
                            state_next = lfwg_pkg::B_DIVIDE;
                        end
                    end
                    lfwg_pkg::OP_TRIANGLE:
                    begin
                        div_den = lfwg_pkg::PERIOD_W'(half);
                        if ((half != '0) &&
                            (below_half || (cmd_reg.step <= {1'b0, cmd_reg.period})))
                        begin
                            div_start  = 1'b1;
                            state_next = lfwg_pkg::B_DIVIDE;
                        end
                    end
                    default:
                    begin
                        div_den = lfwg_pkg::PERIOD_W'(half);
                        div_num = NUM_W'(cmd_reg.step) << (SINE_TABLE_BITS + 1);
                        if (half != '0)
                        begin
                            div_start  = 1'b1;
                            state_next = lfwg_pkg::B_DIVIDE;
                        end
                    end
                endcase
            end
            lfwg_pkg::B_DIVIDE:
            begin
                if (div_done)
                begin
                    if (cmd_reg.op == lfwg_pkg::OP_SINE)
                    begin
                        state_next = lfwg_pkg::B_LOOKUP;
                    end
                    else
                    begin
                        level_next = (div_q > NUM_W'(cmd_reg.max_level))
                                     ? cmd_reg.max_level : div_q[LW-1:0];
                        state_next = lfwg_pkg::B_HOLD;
                    end
                end
            end
            lfwg_pkg::B_LOOKUP:
            begin
                prod_next  = PROD_W'(cmd_reg.max_level[LW-1:1]) * PROD_W'(rom_data);
                state_next = lfwg_pkg::B_SUM;
            end
            lfwg_pkg::B_SUM:
            begin
                level_next = sum[SUM_W-1:SUM_W-LW];
                state_next = lfwg_pkg::B_HOLD;
            end
            lfwg_pkg::B_HOLD:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = lfwg_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = lfwg_pkg::B_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfwg_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        level_reg <= level_next;
        prod_reg  <= prod_next;
        if (out_load)
        begin
            out_level_reg  <= level_reg;
            out_colour_reg <= cmd_reg.colour;
            out_adv_reg    <= cmd_reg.advanced;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.level           = out_level_reg;
    assign result.colour_index    = out_colour_reg;
    assign result.colour_advanced = out_adv_reg;

endmodule

// ===== rtl/led_fade_waveform_generator_unit.sv =====
// Flow: square ticks, and ticks that need no divide (zero divisor, triangle past
// the period), pass the load and hold states; triangle and sawtooth also the divide
// state, sine the divide, lookup and sum states. The shared divider yields one bit
// per cycle of an NUM_W-bit quotient (NUM_W = max(25, SINE_TABLE_BITS + 18), 26 at
// default). Throughput: one level at a time, plus result stalls; a two-entry queue
// keeps accepting ticks meanwhile. Zero ticks and mode none never enter the queue.
// Reset: registers, step counter and colour cleared at once; sine table constant.
module led_fade_waveform_generator_unit #(
    parameter int COLOUR_COUNT    = 8,
    parameter int SINE_TABLE_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    lfwg_tick_if.sink     tick,
    lfwg_result_if.source result,
    lfwg_cfg_if.sink      cfg
);

    logic           push;
    lfwg_pkg::cmd_t push_cmd;
    logic           pop;
    lfwg_pkg::cmd_t head_cmd;
    logic           queue_empty;
    logic           queue_full;

    // tick classification and counters
    lfwg_front #(
        .COLOUR_COUNT (COLOUR_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // command queue
    lfwg_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    // level computation
    lfwg_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .result      (result)
    );

endmodule

// ===== rtl/lfwg_checker.sv =====
// port-level checks for the fade generator, bound to the top level
// depends on lfwg_pkg and led_fade_waveform_generator_unit_macros.svh
`include "led_fade_waveform_generator_unit_macros.svh"

module lfwg_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [lfwg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lfwg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            result_valid,
    input  logic                            result_ready,
    input  logic [lfwg_pkg::LEVEL_W-1:0]    level,
    input  logic [lfwg_pkg::COLOUR_W-1:0]   colour_index,
    input  logic                            colour_advanced
);

    lfwg_pkg::mode_t              mode_shadow_reg;
    logic [lfwg_pkg::LEVEL_W-1:0] max_shadow_reg;

    // shadow of the mode and peak registers from the config channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_shadow_reg <= lfwg_pkg::MODE_NONE;
            max_shadow_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == lfwg_pkg::REG_FADE_MODE)
            begin
                mode_shadow_reg <= lfwg_pkg::mode_t'(cfg_data[2:0]);
            end
            if (cfg_index == lfwg_pkg::REG_MAX_LEVEL)
            begin
                max_shadow_reg <= cfg_data[lfwg_pkg::LEVEL_W-1:0];
            end
        end
    end

    // a stalled result transaction keeps its payload
    `LFWG_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(level) && $stable(colour_index) && $stable(colour_advanced), "result changed while stalled")

    // no level above the programmed peak
    `LFWG_ASSERT_IMP(a_level_peak, clk, rst_n, result_valid, level <= max_shadow_reg, "level above max_level")

    // colour only advances in colour-change mode
    `LFWG_ASSERT_IMP(a_adv_mode, clk, rst_n, result_valid && colour_advanced, mode_shadow_reg == lfwg_pkg::MODE_COLOUR, "colour advanced outside colour mode")

    // square wave is either off or at peak
    `LFWG_ASSERT_IMP(a_square_levels, clk, rst_n, result_valid && (mode_shadow_reg == lfwg_pkg::MODE_SQUARE), (level == '0) || (level == max_shadow_reg), "square level not off or peak")

endmodule

bind led_fade_waveform_generator_unit lfwg_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg.valid),
    .cfg_ready       (cfg.ready),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .level           (result.level),
    .colour_index    (result.colour_index),
    .colour_advanced (result.colour_advanced)
);

// ===== tb/led_fade_waveform_generator_unit_tb.sv =====
// self-checking testbench for the fade waveform generator: tick, result and config channels
// depends on lfwg_pkg, the channel interfaces and led_fade_waveform_generator_unit
`timescale 1ns / 1ps

module led_fade_waveform_generator_unit_tb;

    localparam int          CLK_PERIOD   = 12;
    localparam int          RESET_CYCLES = 5;
    localparam int          COLOURS      = 8;
    localparam int          SINE_BITS    = 8;
    localparam int unsigned QUARTER      = 1 << SINE_BITS;
    localparam int          SETTLE_CYCLES = 48;
    localparam int          ITEM_GOAL     = 1250;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;

    // codes with no member in the package enums
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam logic [1:0] REG_SPARE     = 2'd3;

    // quarter-wave sine builder constants, Q30
    localparam longint unsigned HALF_PI_FIX   = 64'd1686629713;
    localparam longint unsigned UNIT_FIX      = 64'd1 << 30;
    localparam longint unsigned TAYLOR_DIV [5] = '{110, 72, 42, 20, 6};

    typedef struct packed {
        logic [lfwg_pkg::LEVEL_W-1:0]  level;
        logic [lfwg_pkg::COLOUR_W-1:0] colour;
        logic                          advanced;
    } fade_result_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_TICK
    } row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic [1:0]   index;
        logic [15:0]  data;
        logic         value;
        bit           typed;
        fade_result_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    lfwg_tick_if   tick_ch();
    lfwg_result_if result_ch();
    lfwg_cfg_if    cfg_ch();

    led_fade_waveform_generator_unit #(
        .COLOUR_COUNT    (COLOURS),
        .SINE_TABLE_BITS (SINE_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // predictor copy of registers and waveform state
    logic [2:0]        cfg_mode;
    logic [15:0]       cfg_period;
    logic [7:0]        cfg_peak;
    logic [16:0]       step_now;
    int unsigned       colour_now;
    logic [15:0]       sine_rom [0:QUARTER];

    fade_result_t      pending_levels [$];
    plan_row_t         plan [$];
    int unsigned       sent_ticks;
    int unsigned       mismatch_count;
    int unsigned       cycle_count;

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // quarter-wave sine magnitudes, unsigned Q1.15
    function automatic void build_sine_rom();
        longint unsigned angle;
        longint unsigned angle_sq;
        longint unsigned series;
        longint unsigned val;
        for (int i = 0; i <= QUARTER; i++)
        begin
            angle    = (HALF_PI_FIX * 64'(i)) / QUARTER;
            angle_sq = (angle * angle) >> 30;
            series   = UNIT_FIX;
            for (int k = 0; k < 5; k++)
            begin
                series = UNIT_FIX - (((angle_sq * series) >> 30) / TAYLOR_DIV[k]);
            end
            val = (angle * series) >> 30;
            val = (val + 64'd16384) >> 15;
            if (val > 64'd32768)
            begin
                val = 64'd32768;
            end
            sine_rom[i] = val[15:0];
        end
    endfunction

    function automatic logic [7:0] clamp_level(input longint unsigned v, input logic [7:0] peak);
        return (v > peak) ? peak : v[7:0];
    endfunction

    // sine brightness: half amplitude around the midpoint
    function automatic logic [7:0] sine_level(input logic [16:0] step, input logic [15:0] period,
                                              input logic [7:0] peak);
        longint unsigned half;
        longint unsigned phase;
        longint unsigned quad;
        longint unsigned offs;
        longint          mag;
        longint          acc;
        half = 64'(period >> 1);
        if (half == 0)
        begin
            return 8'd0;
        end
        phase = ((64'(step) * 2 * QUARTER) / half) % (4 * QUARTER);
        quad  = phase / QUARTER;
        offs  = phase % QUARTER;
        mag   = (quad % 2 == 1) ? sine_rom[QUARTER - offs] : sine_rom[offs];
        if (quad >= 2)
        begin
            mag = -mag;
        end
        acc = longint'(peak >> 1) * mag + longint'(peak) * 16384;
        if (acc < 0)
        begin
            acc = 0;
        end
        return 8'(acc >>> 15);
    endfunction

    // level for the current step, then step and colour advance; 0 when no result
    function automatic bit next_fade_result(input logic value, output fade_result_t res);
        logic [7:0]  lvl;
        logic [16:0] next_step;
        logic [15:0] half;
        logic        adv;
        res  = '0;
        if (!value)
        begin
            return 1'b0;
        end
        half = cfg_period >> 1;
        case (cfg_mode)
            lfwg_pkg::MODE_SINE, lfwg_pkg::MODE_COLOUR:
                lvl = sine_level(step_now, cfg_period, cfg_peak);
            lfwg_pkg::MODE_SQUARE:
                lvl = (step_now < half) ? cfg_peak : 8'd0;
            lfwg_pkg::MODE_TRIANGLE:
                if (half == 0)
                    lvl = 8'd0;
                else if (step_now < half)
                    lvl = clamp_level((64'(step_now) * cfg_peak) / half, cfg_peak);
                else if (step_now > cfg_period)
                    lvl = 8'd0;
                else
                    lvl = clamp_level((64'(cfg_period - step_now) * cfg_peak) / half,
                                      cfg_peak);
            lfwg_pkg::MODE_SAWTOOTH:
                lvl = (cfg_period == 0) ? 8'd0 :
                      clamp_level((64'(step_now) * cfg_peak) / cfg_period, cfg_peak);
            default:
                return 1'b0;
        endcase
        adv       = 1'b0;
        next_step = step_now + 17'd1;
        if (next_step > cfg_period)
        begin
            next_step = '0;
            if (cfg_mode == lfwg_pkg::MODE_COLOUR)
            begin
                colour_now = (colour_now + 1) % COLOURS;
                adv        = 1'b1;
            end
        end
        step_now     = next_step;
        res.level    = lvl;
        res.colour   = 3'(colour_now);
        res.advanced = adv;
        return 1'b1;
    endfunction

    // directed table builders
    function automatic void plan_write(input logic [1:0] idx, input logic [15:0] value);
        plan_row_t row;
        row       = '{kind: ROW_WRITE, index: idx, data: value, value: 1'b0, typed: 1'b0,
                      want: '0};
        plan.push_back(row);
    endfunction

    function automatic void plan_tick(input logic value);
        plan_row_t row;
        row = '{kind: ROW_TICK, index: '0, data: '0, value: value, typed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic void plan_level(input logic [7:0] lvl, input logic [2:0] col,
                                       input logic adv);
        plan_row_t row;
        row = '{kind: ROW_TICK, index: '0, data: '0, value: 1'b1, typed: 1'b1,
                want: '{level: lvl, colour: col, advanced: adv}};
        plan.push_back(row);
    endfunction

    // hold the inputs quiet until every result is in and the block has settled
    task automatic wait_idle();
        @(negedge clk);
        tick_ch.valid = 1'b0;
        while (pending_levels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one config transaction; predictor registers follow on acceptance
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            lfwg_pkg::REG_FADE_MODE:    cfg_mode   = value[2:0];
            lfwg_pkg::REG_PERIOD_STEPS: cfg_period = value;
            lfwg_pkg::REG_MAX_LEVEL:    cfg_peak   = value[7:0];
            default:                    ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // one tick transaction after a gap; returns at the accepting edge
    task automatic drive_tick(input logic value, input int unsigned gap, input bit typed,
                              input fade_result_t want);
        fade_result_t res;
        @(negedge clk);
        if (gap > 0)
        begin
            tick_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.valid     = 1'b1;
        tick_ch.step_tick = value;
        do @(posedge clk); while (!tick_ch.ready);
        sent_ticks++;
        if (next_fade_result(value, res))
        begin
            pending_levels.push_back(typed ? want : res);
        end
    endtask

    // result sink with random stalls and stall-free stretches
    initial
    begin : result_sink
        int unsigned  stall;
        bit           steady;
        fade_result_t want;
        result_ch.ready = 1'b0;
        steady          = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall != 0)
            begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            if (pending_levels.size() == 0)
            begin
                $error("unexpected result transaction: level %0d colour_index %0d",
                       result_ch.level, result_ch.colour_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_levels.pop_front();
                if (result_ch.level !== want.level)
                begin
                    $error("level: expected %0d, got %0d", want.level, result_ch.level);
                    mismatch_count++;
                end
                if (result_ch.colour_index !== want.colour)
                begin
                    $error("colour_index: expected %0d, got %0d", want.colour,
                           result_ch.colour_index);
                    mismatch_count++;
                end
                if (result_ch.colour_advanced !== want.advanced)
                begin
                    $error("colour_advanced: expected %0d, got %0d", want.advanced,
                           result_ch.colour_advanced);
                    mismatch_count++;
                end
            end
            if ($urandom_range(0, 39) == 0)
            begin
                steady = !steady;
            end
        end
    end

    // reset, directed table, then random phases
    initial
    begin : stimulus
        logic [2:0]  mode;
        logic [15:0] new_period;
        logic [7:0]  new_peak;
        bit          quiet;
        bit          burst;
        int unsigned count;
        rst_n             = 1'b0;
        tick_ch.valid     = 1'b0;
        tick_ch.step_tick = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        cfg_mode          = lfwg_pkg::MODE_NONE;
        cfg_period        = '0;
        cfg_peak          = '0;
        step_now          = '0;
        colour_now        = 0;
        sent_ticks        = 0;
        mismatch_count    = 0;
        cycle_count       = 0;
        build_sine_rom();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // mode none after reset, then a zero tick: neither gives a result
        plan_tick(1'b1);
        plan_tick(1'b0);
        // square, full level in the first half period
        plan_write(lfwg_pkg::REG_FADE_MODE, lfwg_pkg::MODE_SQUARE);
        plan_write(lfwg_pkg::REG_PERIOD_STEPS, 16'd4);
        plan_write(lfwg_pkg::REG_MAX_LEVEL, 16'd255);
        plan_level(8'd255, 3'd0, 1'b0);
        plan_level(8'd255, 3'd0, 1'b0);
        plan_level(8'd0, 3'd0, 1'b0);
        plan_level(8'd0, 3'd0, 1'b0);
        plan_level(8'd0, 3'd0, 1'b0);
        // zero period: sawtooth and triangle with a zero divisor give level zero
        plan_write(lfwg_pkg::REG_FADE_MODE, lfwg_pkg::MODE_SAWTOOTH);
        plan_write(lfwg_pkg::REG_PERIOD_STEPS, 16'd0);
        plan_level(8'd0, 3'd0, 1'b0);
        plan_write(lfwg_pkg::REG_FADE_MODE, lfwg_pkg::MODE_TRIANGLE);
        plan_level(8'd0, 3'd0, 1'b0);
        // unused mode holds the counter, spare register index is ignored
        plan_write(lfwg_pkg::REG_FADE_MODE, MODE_SPARE_LO);
        plan_tick(1'b1);
        plan_write(REG_SPARE, 16'hFFFF);
        // long sawtooth, then a shorter period leaves the step past it
        plan_write(lfwg_pkg::REG_FADE_MODE, lfwg_pkg::MODE_SAWTOOTH);
        plan_write(lfwg_pkg::REG_PERIOD_STEPS, 16'hFFFF);
        plan_level(8'd0, 3'd0, 1'b0);
        plan_level(8'd0, 3'd0, 1'b0);
        plan_level(8'd0, 3'd0, 1'b0);
        plan_write(lfwg_pkg::REG_FADE_MODE, lfwg_pkg::MODE_TRIANGLE);
        plan_write(lfwg_pkg::REG_PERIOD_STEPS, 16'd2);
        plan_level(8'd0, 3'd0, 1'b0);
        // odd period: down ramp at the half point is clamped
        plan_write(lfwg_pkg::REG_PERIOD_STEPS, 16'd3);
        plan_level(8'd0, 3'd0, 1'b0);
        plan_level(8'd255, 3'd0, 1'b0);
        plan_level(8'd255, 3'd0, 1'b0);
        plan_level(8'd0, 3'd0, 1'b0);
        // sawtooth past the period clamps to the peak
        plan_write(lfwg_pkg::REG_FADE_MODE, lfwg_pkg::MODE_SAWTOOTH);
        plan_write(lfwg_pkg::REG_PERIOD_STEPS, 16'hFFFF);
        plan_level(8'd0, 3'd0, 1'b0);
        plan_level(8'd0, 3'd0, 1'b0);
        plan_write(lfwg_pkg::REG_PERIOD_STEPS, 16'd1);
        plan_level(8'd255, 3'd0, 1'b0);
        // sine midpoint, then one step checked by the predictor
        plan_write(lfwg_pkg::REG_FADE_MODE, lfwg_pkg::MODE_SINE);
        plan_write(lfwg_pkg::REG_PERIOD_STEPS, 16'd4);
        plan_level(8'd127, 3'd0, 1'b0);
        plan_tick(1'b1);
        // colour change with zero half period and zero peak
        plan_write(lfwg_pkg::REG_FADE_MODE, lfwg_pkg::MODE_COLOUR);
        plan_write(lfwg_pkg::REG_PERIOD_STEPS, 16'd1);
        plan_write(lfwg_pkg::REG_MAX_LEVEL, 16'd0);
        plan_level(8'd0, 3'd1, 1'b1);
        plan_level(8'd0, 3'd1, 1'b0);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(plan[i].index, plan[i].data);
            end
            else
            begin
                drive_tick(plan[i].value, $urandom_range(0, 6), plan[i].typed, plan[i].want);
            end
        end

        // random phases: new settings while idle, then a run of ticks
        while (sent_ticks < ITEM_GOAL)
        begin
            wait_idle();
            quiet = ($urandom_range(0, 11) == 0);
            if (quiet)
            begin
                case ($urandom_range(0, 2))
                    0:       mode = lfwg_pkg::MODE_NONE;
                    1:       mode = MODE_SPARE_LO;
                    default: mode = MODE_SPARE_HI;
                endcase
            end
            else
            begin
                mode = 3'($urandom_range(lfwg_pkg::MODE_SINE, lfwg_pkg::MODE_COLOUR));
            end
            write_reg(lfwg_pkg::REG_FADE_MODE, {13'($urandom), mode});
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       new_period = ($urandom_range(0, 1) != 0) ? 16'hFFFF :
                                          16'($urandom_range(0, 1));
                    1:       new_period = 16'($urandom);
                    default: new_period = 16'($urandom_range(0, 40));
                endcase
                write_reg(lfwg_pkg::REG_PERIOD_STEPS, new_period);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                if ($urandom_range(0, 4) == 0)
                    new_peak = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                else
                    new_peak = 8'($urandom);
                write_reg(lfwg_pkg::REG_MAX_LEVEL, {8'($urandom), new_peak});
            end
            burst = ($urandom_range(0, 3) == 0);
            count = quiet ? $urandom_range(2, 8) : $urandom_range(10, 60);
            repeat (count)
            begin
                // occasional full drain before the next tick
                if ($urandom_range(0, 49) == 0)
                begin
                    wait_idle();
                end
                drive_tick($urandom_range(0, 9) != 0, burst ? 0 : $urandom_range(0, 6),
                           1'b0, '0);
            end
        end

        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== led_fade_waveform_generator_unit.f =====
+incdir+rtl
rtl/lfwg_pkg.sv
rtl/lfwg_if.sv
rtl/lfwg_fifo.sv
rtl/lfwg_front.sv
rtl/lfwg_divider.sv
rtl/lfwg_sine_rom.sv
rtl/lfwg_back.sv
rtl/led_fade_waveform_generator_unit.sv
rtl/lfwg_checker.sv
tb/led_fade_waveform_generator_unit_tb.sv
